// ===== rtl/tksk_pkg.sv =====
// Shared types and constants for the top-k smallest keeper.
// Depends on nothing; every other file in rtl imports it.
package tksk_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int SCORE_W  = 48;
  localparam int VCOUNT_W = 3;
  localparam int VIDX_W   = 60;
  localparam int START_W  = 10;
  localparam int TTYPE_W  = 7;
  localparam int RANK_W   = 6;

  // cells per read group, selected in the chain's read stage
  localparam int GRP    = 8;
  localparam int GRP_W  = 3;

  // front queue between intake and the sorted chain
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_READ   = 1'b1
  } action_e;

  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [VCOUNT_W-1:0] vcount;
    logic [VIDX_W-1:0]   vidx;
    logic [START_W-1:0]  start;
    logic [TTYPE_W-1:0]  ttype;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    score:  SCORE_MAX,
    vcount: '0,
    vidx:   '0,
    start:  '0,
    ttype:  '0
  };

  // item as classified by the front
  typedef struct packed {
    action_e             action;
    logic                rank_ok;
    logic [RANK_W-1:0]   rank;
    entry_t              ent;
  } item_t;

  // chain stage status handed to the result stage
  typedef struct packed {
    logic valid;
    logic is_read;
    logic rank_ok;
    logic accepted;
  } status_t;

endpackage

// ===== rtl/top_k_smallest_keeper.sv =====
// Top level of the top-k smallest keeper.
// Depends on tksk_pkg, tksk_front, tksk_chain and tksk_result.

// Keeps the CAPACITY entries with the smallest scores, in ascending order,
// and answers rank reads. An item is taken at a rising edge with start high
// and busy low; action 0 offers a candidate, action 1 reads a rank. Every
// item gives exactly one result, shown for one cycle with done_o high. The
// receiver cannot hold results off, so read them in that cycle. An item is
// held in the front queue, then in the chain's cells and status register,
// then in the result registers that drive done_o. The back end retires one
// item per cycle, so busy stays low under a steady stream of one item per
// cycle: the sorted chain compares the new score against all cells at once,
// shifts in parallel, and a read goes through a two-level registered select.
// threshold_score_o reports the worst kept score after the item and is the
// pruning bound for the search. A candidate is kept only when its score is
// strictly below that bound, and lands after any kept entries of equal score.
// After reset every entry holds the all-ones score with a zero payload; an
// all-ones score is never kept. Entry fields are zero for inserts and for
// reads of a rank at or beyond CAPACITY.
module top_k_smallest_keeper #(
  parameter int CAPACITY = tksk_pkg::CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action_i,
  input  logic [tksk_pkg::SCORE_W-1:0]    score_i,
  input  logic [tksk_pkg::VCOUNT_W-1:0]   vertex_count_i,
  input  logic [tksk_pkg::VIDX_W-1:0]     vertex_indices_i,
  input  logic [tksk_pkg::START_W-1:0]    start_index_i,
  input  logic [tksk_pkg::TTYPE_W-1:0]    tiling_type_i,
  input  logic [tksk_pkg::RANK_W-1:0]     read_rank_i,
  output logic                            done_o,
  output logic                            accepted_o,
  output logic [tksk_pkg::SCORE_W-1:0]    threshold_score_o,
  output logic [tksk_pkg::SCORE_W-1:0]    entry_score_o,
  output logic [tksk_pkg::VCOUNT_W-1:0]   entry_vertex_count_o,
  output logic [tksk_pkg::VIDX_W-1:0]     entry_vertex_indices_o,
  output logic [tksk_pkg::START_W-1:0]    entry_start_index_o,
  output logic [tksk_pkg::TTYPE_W-1:0]    entry_tiling_type_o
);
  import tksk_pkg::*;

  localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;
  localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

  logic               pop_valid;
  item_t              pop_item;
  status_t            status;
  logic [NGRP_W-1:0]  grp_sel;
  entry_t             grp_ent [NGRP];
  logic [SCORE_W-1:0] last_score;
  entry_t             entry;

  // intake and queue
  tksk_front #(.CAPACITY(CAPACITY)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .score_i          (score_i),
    .vertex_count_i   (vertex_count_i),
    .vertex_indices_i (vertex_indices_i),
    .start_index_i    (start_index_i),
    .tiling_type_i    (tiling_type_i),
    .read_rank_i      (read_rank_i),
    .pop_valid_o      (pop_valid),
    .pop_item_o       (pop_item)
  );

  // sorted chain: insert, and first read level
  tksk_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_item_i   (pop_item),
    .status_o     (status),
    .grp_sel_o    (grp_sel),
    .grp_ent_o    (grp_ent),
    .last_score_o (last_score)
  );

  // last read level and result registers
  tksk_result #(.CAPACITY(CAPACITY)) u_result (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .status_i          (status),
    .grp_sel_i         (grp_sel),
    .grp_ent_i         (grp_ent),
    .last_score_i      (last_score),
    .done_o            (done_o),
    .accepted_o        (accepted_o),
    .threshold_score_o (threshold_score_o),
    .entry_o           (entry)
  );

  assign entry_score_o          = entry.score;
  assign entry_vertex_count_o   = entry.vcount;
  assign entry_vertex_indices_o = entry.vidx;
  assign entry_start_index_o    = entry.start;
  assign entry_tiling_type_o    = entry.ttype;

endmodule

// ===== rtl/tksk_front.sv =====
// Intake for the top-k smallest keeper: takes items, classifies them and
// queues them for the sorted chain. Depends on tksk_pkg.
module tksk_front #(
  parameter int CAPACITY = tksk_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action_i,
  input  logic [tksk_pkg::SCORE_W-1:0]        score_i,
  input  logic [tksk_pkg::VCOUNT_W-1:0]       vertex_count_i,
  input  logic [tksk_pkg::VIDX_W-1:0]         vertex_indices_i,
  input  logic [tksk_pkg::START_W-1:0]        start_index_i,
  input  logic [tksk_pkg::TTYPE_W-1:0]        tiling_type_i,
  input  logic [tksk_pkg::RANK_W-1:0]         read_rank_i,
  output logic                                pop_valid_o,
  output tksk_pkg::item_t                     pop_item_o
);
  import tksk_pkg::*;

  item_t               q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                push, pop;
  item_t               item_in;

  // classify on the way in
  always_comb begin
    item_in.action     = action_e'(action_i);
    item_in.rank_ok    = int'(read_rank_i) < CAPACITY;
    item_in.rank       = read_rank_i;
    item_in.ent.score  = score_i;
    item_in.ent.vcount = vertex_count_i;
    item_in.ent.vidx   = vertex_indices_i;
    item_in.ent.start  = start_index_i;
    item_in.ent.ttype  = tiling_type_i;
  end

  assign busy        = (cnt_q == QCNT_W'(QDEPTH));
  assign push        = start && !busy;
  assign pop         = (cnt_q != '0);   // chain takes an item every cycle the queue holds one
  assign pop_valid_o = pop;
  assign pop_item_o  = q_mem[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== rtl/tksk_chain.sv =====
// Sorted chain of kept entries with parallel insert, plus the first read
// stage that narrows a rank down to one entry per group. Depends on tksk_pkg.
module tksk_chain #(
  parameter int CAPACITY = tksk_pkg::CAPACITY_DEF,
  localparam int NGRP    = (CAPACITY + tksk_pkg::GRP - 1) / tksk_pkg::GRP,
  localparam int NGRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pop_valid_i,
  input  tksk_pkg::item_t         pop_item_i,
  output tksk_pkg::status_t       status_o,
  output logic [NGRP_W-1:0]       grp_sel_o,
  output tksk_pkg::entry_t        grp_ent_o [NGRP],
  output logic [tksk_pkg::SCORE_W-1:0] last_score_o
);
  import tksk_pkg::*;

  localparam int RI_W = NGRP_W + GRP_W;

  entry_t             cell_q [CAPACITY];
  entry_t             cell_d [CAPACITY];
  logic [CAPACITY-1:0] le;
  logic               do_ins, accept;
  logic [RI_W-1:0]    rank_ext;
  entry_t             hit [NGRP][GRP];
  entry_t             grp_d [NGRP];
  entry_t             grp_q [NGRP];
  status_t            status_q;
  logic [NGRP_W-1:0]  grp_sel_q;

  assign accept   = pop_item_i.ent.score < cell_q[CAPACITY-1].score;
  assign do_ins   = pop_valid_i && (pop_item_i.action == ACT_INSERT) && accept;
  assign rank_ext = RI_W'(pop_item_i.rank);

  // a cell keeps its entry while its score is <= the new one; the first
  // larger cell takes the new entry, the ones behind it shift down by one
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = cell_q[i].score <= pop_item_i.ent.score;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
      if (do_ins && !le[i]) begin
        if (i == 0) begin
          cell_d[i] = pop_item_i.ent;
        end else if (le[i-1]) begin
          cell_d[i] = pop_item_i.ent;
        end else begin
          cell_d[i] = cell_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_q[i] <= ENTRY_RESET;
      end
    end else begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_q[i] <= cell_d[i];
      end
    end
  end

  // read, first level: one entry out of each group of eight
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    for (genvar j = 0; j < GRP; j++) begin : g_cell
      if (g * GRP + j < CAPACITY) begin : g_live
        assign hit[g][j] = cell_q[g * GRP + j];
      end else begin : g_pad
        assign hit[g][j] = '0;
      end
    end
    assign grp_d[g] = hit[g][rank_ext[GRP_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_q[g] <= grp_d[g];
    end
    grp_sel_q <= rank_ext[RI_W-1:GRP_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
    end else begin
      status_q.valid    <= pop_valid_i;
      status_q.is_read  <= pop_item_i.action == ACT_READ;
      status_q.rank_ok  <= pop_item_i.rank_ok;
      status_q.accepted <= do_ins;
    end
  end

  assign status_o     = status_q;
  assign grp_sel_o    = grp_sel_q;
  assign grp_ent_o    = grp_q;
  assign last_score_o = cell_q[CAPACITY-1].score;

endmodule

// ===== rtl/tksk_result.sv =====
// Result stage: final group select for reads and the registered result
// ports with their strobe. Depends on tksk_pkg.
module tksk_result #(
  parameter int CAPACITY = tksk_pkg::CAPACITY_DEF,
  localparam int NGRP    = (CAPACITY + tksk_pkg::GRP - 1) / tksk_pkg::GRP,
  localparam int NGRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tksk_pkg::status_t             status_i,
  input  logic [NGRP_W-1:0]             grp_sel_i,
  input  tksk_pkg::entry_t              grp_ent_i [NGRP],
  input  logic [tksk_pkg::SCORE_W-1:0]  last_score_i,
  output logic                          done_o,
  output logic                          accepted_o,
  output logic [tksk_pkg::SCORE_W-1:0]  threshold_score_o,
  output tksk_pkg::entry_t              entry_o
);
  import tksk_pkg::*;

  logic   done_q, accepted_q;
  logic [SCORE_W-1:0] thr_q;
  entry_t ent_d, ent_q;

  always_comb begin
    ent_d = '0;
    if (status_i.is_read && status_i.rank_ok) begin
      ent_d = grp_ent_i[grp_sel_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      accepted_q <= 1'b0;
      thr_q      <= SCORE_MAX;
    end else begin
      done_q     <= status_i.valid;
      accepted_q <= status_i.valid && status_i.accepted;
      if (status_i.valid) begin
        thr_q <= last_score_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (status_i.valid) begin
      ent_q <= ent_d;
    end
  end

  assign done_o            = done_q;
  assign accepted_o        = accepted_q;
  assign threshold_score_o = thr_q;
  assign entry_o           = ent_q;

endmodule

// ===== rtl/tksk_checker.sv =====
// Port-level checks for the top-k smallest keeper, bound to the top level.
// Depends on tksk_pkg.
module tksk_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          done_o,
  input logic                          accepted_o,
  input logic [tksk_pkg::SCORE_W-1:0]  threshold_score_o,
  input logic [tksk_pkg::SCORE_W-1:0]  entry_score_o
);
  import tksk_pkg::*;

  // the kept set only improves: the threshold never rises
  a_thr_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    threshold_score_o <= $past(threshold_score_o))
    else $error("threshold rose");

  // accepted is only shown with a result
  a_acc_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted_o |-> done_o)
    else $error("accepted without result strobe");

  // an accepted insert result carries a zero entry score
  a_acc_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && accepted_o) |-> (entry_score_o == '0))
    else $error("insert result with entry score");

  // a read never returns a score worse than the kept threshold
  a_entry_le_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (entry_score_o <= threshold_score_o))
    else $error("read entry above threshold");

endmodule

bind top_k_smallest_keeper tksk_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .done_o            (done_o),
  .accepted_o        (accepted_o),
  .threshold_score_o (threshold_score_o),
  .entry_score_o     (entry_score_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for top_k_smallest_keeper.
// Depends on tksk_pkg and the block itself; directed items first, then random ones.
`timescale 1ns / 100ps

module tb_top;
  import tksk_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CALM_TAIL = 200;      // last random items are sent with no idling
  localparam int DRAIN_CYCLES = 10;    // results pass the front queue, chain and result registers after intake
  localparam int MAX_REPORTS = 10;

  // 999999999.9 with 16 fraction bits; below all ones
  localparam logic [SCORE_W-1:0] DECIMAL_CAP = 48'd65535999993446;

  // one result as seen on the ports
  typedef struct packed {
    logic               accepted;
    logic [SCORE_W-1:0] thr;
    entry_t             ent;
  } outcome_t;

  // one directed or random item, with an optional typed-in expectation
  typedef struct {
    action_e             act;
    logic [SCORE_W-1:0]  score;
    logic [VCOUNT_W-1:0] vcount;
    logic [VIDX_W-1:0]   vidx;
    logic [START_W-1:0]  sidx;
    logic [TTYPE_W-1:0]  ttype;
    logic [RANK_W-1:0]   rank;
    bit                  pinned;
    outcome_t            want;
  } row_t;

  localparam outcome_t NO_PIN = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  // stimulus registers, changed only at the falling edge
  logic                start_r;
  action_e             action_r;
  logic [SCORE_W-1:0]  score_r;
  logic [VCOUNT_W-1:0] vcount_r;
  logic [VIDX_W-1:0]   vidx_r;
  logic [START_W-1:0]  sidx_r;
  logic [TTYPE_W-1:0]  ttype_r;
  logic [RANK_W-1:0]   rank_r;
  bit                  pinned_r;
  outcome_t            want_r;

  logic                busy;
  logic                done_o;
  logic                accepted_o;
  logic [SCORE_W-1:0]  threshold_score_o;
  logic [SCORE_W-1:0]  entry_score_o;
  logic [VCOUNT_W-1:0] entry_vertex_count_o;
  logic [VIDX_W-1:0]   entry_vertex_indices_o;
  logic [START_W-1:0]  entry_start_index_o;
  logic [TTYPE_W-1:0]  entry_tiling_type_o;

  // shadow copy of the kept list, index 0 holds the smallest score
  entry_t   kept_list [CAP];
  outcome_t pending_results [$];
  row_t     directed_rows [$];

  int unsigned mismatches  = 0;
  int unsigned checked     = 0;
  int unsigned inserts     = 0;
  int unsigned inserts_hit = 0;
  int unsigned reads       = 0;

  top_k_smallest_keeper dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .start                  (start_r),
    .busy                   (busy),
    .action_i               (action_r),
    .score_i                (score_r),
    .vertex_count_i         (vcount_r),
    .vertex_indices_i       (vidx_r),
    .start_index_i          (sidx_r),
    .tiling_type_i          (ttype_r),
    .read_rank_i            (rank_r),
    .done_o                 (done_o),
    .accepted_o             (accepted_o),
    .threshold_score_o      (threshold_score_o),
    .entry_score_o          (entry_score_o),
    .entry_vertex_count_o   (entry_vertex_count_o),
    .entry_vertex_indices_o (entry_vertex_indices_o),
    .entry_start_index_o    (entry_start_index_o),
    .entry_tiling_type_o    (entry_tiling_type_o)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicts the result of one item and updates the shadow list. A candidate
  // goes in only when strictly below the worst kept score; it lands after all
  // kept entries of equal score and the last entry falls off the end.
  function automatic outcome_t keeper_apply(input action_e act, input entry_t cand,
                                            input logic [RANK_W-1:0] rank);
    outcome_t res;
    int pos;
    res = '0;
    if (act == ACT_INSERT) begin
      if (cand.score < kept_list[CAP-1].score) begin
        pos = 0;
        while (pos < CAP - 1 && kept_list[pos].score <= cand.score) pos++;
        for (int i = CAP - 1; i > pos; i--) kept_list[i] = kept_list[i-1];
        kept_list[pos] = cand;
        res.accepted = 1'b1;
      end
    end else if (rank < CAP) begin
      res.ent = kept_list[rank];
    end
    res.thr = kept_list[CAP-1].score;
    return res;
  endfunction

  function automatic row_t mk_row(input action_e act, input logic [SCORE_W-1:0] score,
                                  input logic [VCOUNT_W-1:0] vcount,
                                  input logic [VIDX_W-1:0] vidx,
                                  input logic [START_W-1:0] sidx,
                                  input logic [TTYPE_W-1:0] ttype,
                                  input logic [RANK_W-1:0] rank,
                                  input bit pinned, input outcome_t want);
    row_t r;
    r.act = act;       r.score = score; r.vcount = vcount; r.vidx = vidx;
    r.sidx = sidx;     r.ttype = ttype; r.rank = rank;
    r.pinned = pinned; r.want = want;
    return r;
  endfunction

  // Random item. Scores are biased towards the interesting spots: exactly
  // the threshold (must be refused), just under it, copies of kept scores
  // (ties), a narrow low band and the all-ones sentinel.
  function automatic row_t rand_row();
    row_t r;
    logic [SCORE_W-1:0] thr;
    thr = kept_list[CAP-1].score;
    r = mk_row($urandom_range(0, 9) < 6 ? ACT_INSERT : ACT_READ, '0,
               VCOUNT_W'($urandom_range(0, 7)), VIDX_W'({$urandom, $urandom}),
               START_W'($urandom), TTYPE_W'($urandom),
               RANK_W'($urandom_range(0, CAP - 1)), 1'b0, NO_PIN);
    case ($urandom_range(0, 9))
      0, 1:    r.score = SCORE_W'({$urandom, $urandom});
      2, 3:    r.score = SCORE_W'($urandom_range(0, 300));
      4:       r.score = thr;
      5:       r.score = (thr != '0) ? thr - 1'b1 : thr;
      6:       r.score = kept_list[RANK_W'($urandom_range(0, CAP - 1))].score;
      7:       r.score = SCORE_MAX;
      default: r.score = SCORE_W'({$urandom, $urandom} >> $urandom_range(8, 40));
    endcase
    return r;
  endfunction

  task automatic scramble_inputs();
    action_r <= action_e'($urandom_range(0, 1));
    score_r  <= SCORE_W'({$urandom, $urandom});
    vcount_r <= VCOUNT_W'($urandom);
    vidx_r   <= VIDX_W'({$urandom, $urandom});
    sidx_r   <= START_W'($urandom);
    ttype_r  <= TTYPE_W'($urandom);
    rank_r   <= RANK_W'($urandom);
  endtask

  // Presents one item from the current falling edge until the block takes it;
  // returns at the falling edge after intake.
  task automatic send_item(input row_t r);
    bit taken;
    action_r <= r.act;
    score_r  <= r.score;
    vcount_r <= r.vcount;
    vidx_r   <= r.vidx;
    sidx_r   <= r.sidx;
    ttype_r  <= r.ttype;
    rank_r   <= r.rank;
    pinned_r <= r.pinned;
    want_r   <= r.want;
    start_r  <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = (busy === 1'b0);
      @(negedge clk_i);
    end
  endtask

  // start low for the burst, fields wander meanwhile; each signal is assigned
  // once per falling edge, the last edge is left to the next send_item
  task automatic idle_burst(input int n);
    start_r <= 1'b0;
    scramble_inputs();
    repeat (n - 1) begin
      @(negedge clk_i);
      scramble_inputs();
    end
    @(negedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got)
      $display("  %s: expected %h, got %h", name, want, got);
  endtask

  task automatic check_result(input outcome_t want, input outcome_t got);
    checked++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] mismatch on result %0d", $realtime, checked);
        report_field("accepted", 64'(want.accepted), 64'(got.accepted));
        report_field("threshold_score", 64'(want.thr), 64'(got.thr));
        report_field("entry_score", 64'(want.ent.score), 64'(got.ent.score));
        report_field("entry_vertex_count", 64'(want.ent.vcount), 64'(got.ent.vcount));
        report_field("entry_vertex_indices", 64'(want.ent.vidx), 64'(got.ent.vidx));
        report_field("entry_start_index", 64'(want.ent.start), 64'(got.ent.start));
        report_field("entry_tiling_type", 64'(want.ent.ttype), 64'(got.ent.ttype));
      end
    end
  endtask

  // Intake and result checking share one process so that, at a given edge,
  // the result leaving is matched before the item arriving is queued. Both
  // read pre-edge values, the block's flops update later in the step.
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t predicted;
    if (rst_ni === 1'b1) begin
      if (done_o === 1'b1) begin
        got = '{accepted: accepted_o, thr: threshold_score_o,
                ent: '{score: entry_score_o, vcount: entry_vertex_count_o,
                       vidx: entry_vertex_indices_o, start: entry_start_index_o,
                       ttype: entry_tiling_type_o}};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result with no item outstanding", $realtime);
        end else begin
          check_result(pending_results.pop_front(), got);
        end
      end
      if (start_r === 1'b1 && busy === 1'b0) begin
        predicted = keeper_apply(action_r,
                                 '{score: score_r, vcount: vcount_r, vidx: vidx_r,
                                   start: sidx_r, ttype: ttype_r}, rank_r);
        if (action_r == ACT_INSERT) begin
          inserts++;
          if (predicted.accepted) inserts_hit++;
        end else begin
          reads++;
        end
        // typed-in rows override the predictor, which still tracks the state
        pending_results.push_back(pinned_r ? want_r : predicted);
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    row_t r;
    int guard;
    rst_ni   = 1'b0;
    start_r  = 1'b0;
    action_r = ACT_INSERT;
    score_r  = '0;
    vcount_r = '0;
    vidx_r   = '0;
    sidx_r   = '0;
    ttype_r  = '0;
    rank_r   = '0;
    pinned_r = 1'b0;
    want_r   = '0;
    for (int i = 0; i < CAP; i++) kept_list[i] = ENTRY_RESET;

    // Directed part. After reset ranks 0 and 63 read the sentinel with a zero
    // payload; an all-ones score is refused; a full payload must come back
    // whole, vertex count 7 included; ties go behind the earlier entry.
    directed_rows.push_back(mk_row(ACT_READ, '0, '0, '0, '0, '0, 6'd0, 1'b1,
                                   '{accepted: 1'b0, thr: SCORE_MAX, ent: ENTRY_RESET}));
    directed_rows.push_back(mk_row(ACT_READ, '0, '0, '0, '0, '0, 6'd63, 1'b1,
                                   '{accepted: 1'b0, thr: SCORE_MAX, ent: ENTRY_RESET}));
    directed_rows.push_back(mk_row(ACT_INSERT, SCORE_MAX, '1, '1, '1, '1, '0, 1'b1,
                                   '{accepted: 1'b0, thr: SCORE_MAX, ent: '0}));
    directed_rows.push_back(mk_row(ACT_INSERT, '0, '1, '1, '1, '1, '0, 1'b1,
                                   '{accepted: 1'b1, thr: SCORE_MAX, ent: '0}));
    directed_rows.push_back(mk_row(ACT_READ, '0, '0, '0, '0, '0, 6'd0, 1'b1,
                                   '{accepted: 1'b0, thr: SCORE_MAX,
                                     ent: '{score: '0, vcount: '1, vidx: '1,
                                            start: '1, ttype: '1}}));
    directed_rows.push_back(mk_row(ACT_INSERT, '0, 3'd0, 60'h0123456789abcde,
                                   10'h155, 7'h2a, '0, 1'b0, NO_PIN));
    directed_rows.push_back(mk_row(ACT_READ, '0, '0, '0, '0, '0, 6'd0, 1'b0, NO_PIN));
    directed_rows.push_back(mk_row(ACT_READ, '0, '0, '0, '0, '0, 6'd1, 1'b0, NO_PIN));
    directed_rows.push_back(mk_row(ACT_INSERT, DECIMAL_CAP, 3'd6, 60'hfedcba987654321,
                                   10'h2aa, 7'h55, '0, 1'b0, NO_PIN));
    directed_rows.push_back(mk_row(ACT_INSERT, SCORE_MAX - 1'b1, 3'd3, '0, '0, 7'd1,
                                   '0, 1'b0, NO_PIN));
    directed_rows.push_back(mk_row(ACT_INSERT, 48'd1, 3'd6, 60'h3ff, 10'd1, 7'd93,
                                   '0, 1'b0, NO_PIN));
    directed_rows.push_back(mk_row(ACT_INSERT, DECIMAL_CAP, 3'd7, 60'h555555555555555,
                                   10'd512, 7'd64, '0, 1'b0, NO_PIN));
    directed_rows.push_back(mk_row(ACT_INSERT, 48'h8000_0000_0000, 3'd2,
                                   60'haaaaaaaaaaaaaaa, 10'd7, 7'd17, '0, 1'b0, NO_PIN));
    for (int k = 0; k < 7; k++)
      directed_rows.push_back(mk_row(ACT_READ, '0, '0, '0, '0, '0, RANK_W'(k), 1'b0,
                                     NO_PIN));
    directed_rows.push_back(mk_row(ACT_READ, '0, '0, '0, '0, '0, 6'd63, 1'b0, NO_PIN));

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i]);
      if ($urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 6));
    end

    // Random part. The kept list fills within the first hundred or so
    // inserts, after which the threshold falls and ties and refusals dominate.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = rand_row();
      send_item(r);
      if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
        idle_burst($urandom_range(1, 6));
    end
    start_r <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      mismatches += pending_results.size();
      $display("%0d results never arrived", pending_results.size());
    end

    $display("Covered %0d inserts (%0d kept) and %0d rank reads; %0d results checked.",
             inserts, inserts_hit, reads, checked);
    $display("Final threshold %h, %0d mismatching results.",
             kept_list[CAP-1].score, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tksk_pkg.sv
rtl/tksk_front.sv
rtl/tksk_chain.sv
rtl/tksk_result.sv
rtl/top_k_smallest_keeper.sv
rtl/tksk_checker.sv
tb/tb_top.sv
